@@ hdl/jdt_pkg.sv @@
// shared types, codes and helpers of the jtag debug transport
package jdt_pkg;

   localparam int unsigned DATA_W       = 64;
   localparam int unsigned LEN_W        = 7;
   localparam int unsigned IR_W         = 5;
   localparam int unsigned ABITS_W      = 5;
   localparam int unsigned DM_ADDR_W    = 30;
   localparam int unsigned DM_DATA_W    = 32;
   localparam int unsigned DMI_RESULT_W = DM_DATA_W + 2;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam logic [IR_W-1:0] IR_IDCODE = 5'h01;
   localparam logic [IR_W-1:0] IR_DTMCS  = 5'h10;
   localparam logic [IR_W-1:0] IR_DMI    = 5'h11;
   localparam logic [IR_W-1:0] IR_BYPASS = 5'h1f;

   localparam logic [1:0] DMI_OP_NOP   = 2'd0;
   localparam logic [1:0] DMI_OP_READ  = 2'd1;
   localparam logic [1:0] DMI_OP_WRITE = 2'd2;

   localparam logic [1:0] DMI_STATUS_OK     = 2'd0;
   localparam logic [1:0] DMI_STATUS_FAILED = 2'd2;

   localparam logic CSR_ADDRESS_BITS = 1'b0;
   localparam logic CSR_ID_CODE      = 1'b1;

   localparam logic [ABITS_W-1:0]   ABITS_RESET   = 5'd7;
   localparam logic [DM_DATA_W-1:0] ID_CODE_RESET = 32'hdeadbeef;
   localparam logic [ABITS_W-1:0]   ABITS_MIN     = 5'd1;
   localparam logic [ABITS_W-1:0]   ABITS_MAX     = 5'd30;
   localparam logic [LEN_W-1:0]     LEN_WORD      = 7'd32;
   localparam logic [LEN_W-1:0]     LEN_DMI_FIXED = 7'd34;
   localparam logic [LEN_W-1:0]     LEN_BYPASS    = 7'd1;
   localparam logic [LEN_W-1:0]     LEN_MAX       = 7'd64;
   localparam int unsigned          DTMCS_BUSY_BIT  = 18;
   localparam int unsigned          DTMCS_ABITS_LSB = 4;

   typedef enum logic [3:0] {
      TAP_RESET      = 4'd0,
      TAP_IDLE       = 4'd1,
      TAP_SELECT_DR  = 4'd2,
      TAP_CAPTURE_DR = 4'd3,
      TAP_SHIFT_DR   = 4'd4,
      TAP_EXIT1_DR   = 4'd5,
      TAP_PAUSE_DR   = 4'd6,
      TAP_EXIT2_DR   = 4'd7,
      TAP_UPDATE_DR  = 4'd8,
      TAP_SELECT_IR  = 4'd9,
      TAP_CAPTURE_IR = 4'd10,
      TAP_SHIFT_IR   = 4'd11,
      TAP_EXIT1_IR   = 4'd12,
      TAP_PAUSE_IR   = 4'd13,
      TAP_EXIT2_IR   = 4'd14,
      TAP_UPDATE_IR  = 4'd15
   } tap_state_type;

   typedef struct packed {
      logic [ABITS_W-1:0]   address_bits;
      logic [DM_DATA_W-1:0] id_code;
   } cfg_type;

   typedef struct packed {
      logic                 tck;
      logic                 tms;
      logic                 tdi;
      logic [DM_DATA_W-1:0] dm_read_data;
      logic                 dm_ok;
   } item_type;

   typedef struct packed {
      logic                 tdo;
      tap_state_type        tap_state;
      logic                 dmi_req_valid;
      logic                 dmi_req_write;
      logic [DM_ADDR_W-1:0] dmi_req_addr;
      logic [DM_DATA_W-1:0] dmi_req_data;
   } result_type;

   function automatic tap_state_type tap_next(input tap_state_type cur, input logic tms);
      tap_state_type nxt;
      case (cur)
         TAP_RESET:      nxt = tms ? TAP_RESET     : TAP_IDLE;
         TAP_IDLE:       nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
         TAP_SELECT_DR:  nxt = tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
         TAP_CAPTURE_DR: nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
         TAP_SHIFT_DR:   nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
         TAP_EXIT1_DR:   nxt = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
         TAP_PAUSE_DR:   nxt = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
         TAP_EXIT2_DR:   nxt = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
         TAP_UPDATE_DR:  nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
         TAP_SELECT_IR:  nxt = tms ? TAP_RESET     : TAP_CAPTURE_IR;
         TAP_CAPTURE_IR: nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
         TAP_SHIFT_IR:   nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
         TAP_EXIT1_IR:   nxt = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
         TAP_PAUSE_IR:   nxt = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
         TAP_EXIT2_IR:   nxt = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
         TAP_UPDATE_IR:  nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
         default:        nxt = TAP_RESET;
      endcase
      return nxt;
   endfunction

   function automatic logic [ABITS_W-1:0] eff_abits(input logic [ABITS_W-1:0] raw);
      logic [ABITS_W-1:0] a;
      a = raw;
      if (raw < ABITS_MIN) begin
         a = ABITS_MIN;
      end else if (raw > ABITS_MAX) begin
         a = ABITS_MAX;
      end
      return a;
   endfunction

endpackage

@@ hdl/jtag_debug_transport_core.sv @@
// top level of the jtag debug transport: item handshake, result register and csr port
// Each req item is one sample of the JTAG pins (tck, tms, tdi) together with the debug
// module's reply to any request issued by that same sample. The TAP state, scan
// registers and DMI decode advance in the cycle the item is accepted and the result
// item is registered, so one item is taken every clock cycle;
// the only limit is the result register, which accepts a new item whenever it is empty
// or being read in the same cycle. Registers: address_bits at byte 0, id_code at byte 4.
module jtag_debug_transport_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tck,
   input  logic                                req_tms,
   input  logic                                req_tdi,
   input  logic [jdt_pkg::DM_DATA_W-1:0]       req_dm_read_data,
   input  logic                                req_dm_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_tdo,
   output logic [3:0]                          rsp_tap_state,
   output logic                                rsp_dmi_req_valid,
   output logic                                rsp_dmi_req_write,
   output logic [jdt_pkg::DM_ADDR_W-1:0]       rsp_dmi_req_addr,
   output logic [jdt_pkg::DM_DATA_W-1:0]       rsp_dmi_req_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [jdt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [jdt_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [jdt_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   jdt_pkg::cfg_type    cfg;
   jdt_pkg::item_type   item;
   jdt_pkg::result_type result;
   jdt_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign item.tck          = req_tck;
   assign item.tms          = req_tms;
   assign item.tdi          = req_tdi;
   assign item.dm_read_data = req_dm_read_data;
   assign item.dm_ok        = req_dm_ok;

   jdt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   jdt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tdo           = rsp_ff.tdo;
   assign rsp_tap_state     = rsp_ff.tap_state;
   assign rsp_dmi_req_valid = rsp_ff.dmi_req_valid;
   assign rsp_dmi_req_write = rsp_ff.dmi_req_write;
   assign rsp_dmi_req_addr  = rsp_ff.dmi_req_addr;
   assign rsp_dmi_req_data  = rsp_ff.dmi_req_data;

endmodule

@@ hdl/jdt_csr.sv @@
// configuration registers behind the apb-style port
module jdt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [jdt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [jdt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [jdt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output jdt_pkg::cfg_type                   cfg
);

   logic [jdt_pkg::ABITS_W-1:0]   address_bits_ff, address_bits_in;
   logic [jdt_pkg::DM_DATA_W-1:0] id_code_ff, id_code_in;
   logic                          wr_en;
   logic                          reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      address_bits_in = address_bits_ff;
      id_code_in      = id_code_ff;
      if (wr_en) begin
         case (reg_sel)
            jdt_pkg::CSR_ADDRESS_BITS: address_bits_in = pwdata[jdt_pkg::ABITS_W-1:0];
            jdt_pkg::CSR_ID_CODE:      id_code_in      = pwdata;
            default:                   address_bits_in = address_bits_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         jdt_pkg::CSR_ADDRESS_BITS: prdata = {{(jdt_pkg::CSR_DATA_W-jdt_pkg::ABITS_W){1'b0}},
                                              address_bits_ff};
         jdt_pkg::CSR_ID_CODE:      prdata = id_code_ff;
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_bits_ff <= jdt_pkg::ABITS_RESET;
         id_code_ff      <= jdt_pkg::ID_CODE_RESET;
      end else begin
         address_bits_ff <= address_bits_in;
         id_code_ff      <= id_code_in;
      end
   end

   assign cfg.address_bits = address_bits_ff;
   assign cfg.id_code      = id_code_ff;

endmodule

@@ hdl/jdt_core.sv @@
// tap controller, scan registers and dmi request decode
module jdt_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  jdt_pkg::item_type    item,
   input  jdt_pkg::cfg_type     cfg,
   output jdt_pkg::result_type  result
);

   logic                             last_tck_ff, last_tck_in;
   logic                             last_tms_ff, last_tms_in;
   logic                             last_tdi_ff, last_tdi_in;
   logic                             tdo_ff, tdo_in;
   jdt_pkg::tap_state_type           tap_state_ff, tap_state_in;
   logic [jdt_pkg::IR_W-1:0]         instr_ff, instr_in;
   logic [jdt_pkg::DATA_W-1:0]       data_shift_ff, data_shift_in;
   logic [jdt_pkg::LEN_W-1:0]        data_length_ff, data_length_in;
   logic [jdt_pkg::DMI_RESULT_W-1:0] dmi_result_ff, dmi_result_in;
   logic                             busy_ff, busy_in;

   logic [jdt_pkg::ABITS_W-1:0]      abits;
   logic [5:0]                       ins_idx;
   logic [jdt_pkg::LEN_W-1:0]        len_m1;
   logic [jdt_pkg::DM_ADDR_W:0]      addr_mask;
   logic [jdt_pkg::DM_ADDR_W-1:0]    scan_addr;
   logic [1:0]                       dm_status;

   always_comb begin
      abits     = jdt_pkg::eff_abits(cfg.address_bits);
      len_m1    = data_length_ff - 7'd1;
      if (data_length_ff == '0) begin
         ins_idx = '0;
      end else if (data_length_ff > jdt_pkg::LEN_MAX) begin
         ins_idx = 6'd63;
      end else begin
         ins_idx = len_m1[5:0];
      end
      addr_mask = ({{jdt_pkg::DM_ADDR_W{1'b0}}, 1'b1} << abits) - 31'd1;
      scan_addr = data_shift_ff[jdt_pkg::DATA_W-1:jdt_pkg::DMI_RESULT_W]
                  & addr_mask[jdt_pkg::DM_ADDR_W-1:0];
      dm_status = item.dm_ok ? jdt_pkg::DMI_STATUS_OK : jdt_pkg::DMI_STATUS_FAILED;

      last_tck_in    = last_tck_ff;
      last_tms_in    = last_tms_ff;
      last_tdi_in    = last_tdi_ff;
      tdo_in         = tdo_ff;
      tap_state_in   = tap_state_ff;
      instr_in       = instr_ff;
      data_shift_in  = data_shift_ff;
      data_length_in = data_length_ff;
      dmi_result_in  = dmi_result_ff;
      busy_in        = busy_ff;

      result.dmi_req_valid = 1'b0;
      result.dmi_req_write = 1'b0;
      result.dmi_req_addr  = '0;
      result.dmi_req_data  = '0;

      if (step) begin
         if (!last_tck_ff && item.tck) begin
            // rising tck: shift with the kept tdi, advance with the kept tms
            if (tap_state_ff == jdt_pkg::TAP_SHIFT_DR) begin
               data_shift_in = (data_shift_ff >> 1)
                               | ({{(jdt_pkg::DATA_W-1){1'b0}}, last_tdi_ff} << ins_idx);
            end else if (tap_state_ff == jdt_pkg::TAP_SHIFT_IR) begin
               instr_in = {last_tdi_ff, instr_ff[jdt_pkg::IR_W-1:1]};
            end
            tap_state_in = jdt_pkg::tap_next(tap_state_ff, last_tms_ff);
         end else if (last_tck_ff && !item.tck) begin
            case (tap_state_ff)
               jdt_pkg::TAP_CAPTURE_DR: begin
                  case (instr_ff)
                     jdt_pkg::IR_IDCODE: begin
                        data_shift_in  = {32'd0, cfg.id_code};
                        data_length_in = jdt_pkg::LEN_WORD;
                     end
                     jdt_pkg::IR_DTMCS: begin
                        data_shift_in  = '0;
                        data_shift_in[jdt_pkg::DTMCS_BUSY_BIT] = busy_ff;
                        data_shift_in[jdt_pkg::DTMCS_ABITS_LSB +: jdt_pkg::ABITS_W] = abits;
                        data_shift_in[0] = 1'b1;
                        data_length_in = jdt_pkg::LEN_WORD;
                     end
                     jdt_pkg::IR_DMI: begin
                        data_shift_in  = {{(jdt_pkg::DATA_W-jdt_pkg::DMI_RESULT_W){1'b0}},
                                          dmi_result_ff};
                        data_length_in = {2'b00, abits} + jdt_pkg::LEN_DMI_FIXED;
                     end
                     default: begin
                        data_shift_in  = '0;
                        data_length_in = jdt_pkg::LEN_BYPASS;
                     end
                  endcase
               end
               jdt_pkg::TAP_UPDATE_DR: begin
                  if (instr_ff == jdt_pkg::IR_DMI) begin
                     case (data_shift_ff[1:0])
                        jdt_pkg::DMI_OP_READ: begin
                           result.dmi_req_valid = 1'b1;
                           result.dmi_req_addr  = scan_addr;
                           dmi_result_in        = {item.dm_read_data, dm_status};
                           busy_in              = !item.dm_ok;
                        end
                        jdt_pkg::DMI_OP_WRITE: begin
                           result.dmi_req_valid = 1'b1;
                           result.dmi_req_write = 1'b1;
                           result.dmi_req_addr  = scan_addr;
                           result.dmi_req_data  = data_shift_ff[jdt_pkg::DMI_RESULT_W-1:2];
                           dmi_result_in        = {32'd0, dm_status};
                           busy_in              = !item.dm_ok;
                        end
                        default: begin
                           // nop and reserved op clear the result and busy flag
                           dmi_result_in = '0;
                           busy_in       = 1'b0;
                        end
                     endcase
                  end
               end
               jdt_pkg::TAP_SHIFT_DR: tdo_in = data_shift_ff[0];
               jdt_pkg::TAP_SHIFT_IR: tdo_in = instr_ff[0];
               default:               tdo_in = tdo_ff;
            endcase
         end
         last_tck_in = item.tck;
         last_tms_in = item.tms;
         last_tdi_in = item.tdi;
      end

      result.tdo       = tdo_in;
      result.tap_state = tap_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tck_ff    <= 1'b0;
         last_tms_ff    <= 1'b0;
         last_tdi_ff    <= 1'b0;
         tdo_ff         <= 1'b0;
         tap_state_ff   <= jdt_pkg::TAP_RESET;
         instr_ff       <= jdt_pkg::IR_IDCODE;
         data_shift_ff  <= '0;
         data_length_ff <= jdt_pkg::LEN_BYPASS;
         dmi_result_ff  <= '0;
         busy_ff        <= 1'b0;
      end else begin
         last_tck_ff    <= last_tck_in;
         last_tms_ff    <= last_tms_in;
         last_tdi_ff    <= last_tdi_in;
         tdo_ff         <= tdo_in;
         tap_state_ff   <= tap_state_in;
         instr_ff       <= instr_in;
         data_shift_ff  <= data_shift_in;
         data_length_ff <= data_length_in;
         dmi_result_ff  <= dmi_result_in;
         busy_ff        <= busy_in;
      end
   end

endmodule

@@ sim/jtag_debug_transport_checker.sv @@
// scoreboard for the jtag debug transport: predicts each result item and compares it
`timescale 1ns / 1ps

module jtag_debug_transport_checker
   import jdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_tck,
   input  logic                  req_tms,
   input  logic                  req_tdi,
   input  logic [DM_DATA_W-1:0]  req_dm_read_data,
   input  logic                  req_dm_ok,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_tdo,
   input  logic [3:0]            rsp_tap_state,
   input  logic                  rsp_dmi_req_valid,
   input  logic                  rsp_dmi_req_write,
   input  logic [DM_ADDR_W-1:0]  rsp_dmi_req_addr,
   input  logic [DM_DATA_W-1:0]  rsp_dmi_req_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending
);

   result_type           expected_q[$];

   logic [ABITS_W-1:0]   cfg_abits;
   logic [DM_DATA_W-1:0] cfg_id;

   logic                 prev_tck;
   logic                 prev_tms;
   logic                 prev_tdi;
   logic                 tdo_q;
   tap_state_type        tap;
   logic [IR_W-1:0]      ir;
   logic [DATA_W-1:0]    scan;
   logic [LEN_W-1:0]     scan_len;
   logic [DMI_RESULT_W-1:0] dmi_res;
   logic                 busy;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // successor pair of a tap state, {on tms high, on tms low}
   function automatic tap_state_type tap_after(input tap_state_type s, input logic tms);
      tap_state_type hi;
      tap_state_type lo;
      case (s)
         TAP_RESET:      begin hi = TAP_RESET;     lo = TAP_IDLE;       end
         TAP_IDLE:       begin hi = TAP_SELECT_DR; lo = TAP_IDLE;       end
         TAP_SELECT_DR:  begin hi = TAP_SELECT_IR; lo = TAP_CAPTURE_DR; end
         TAP_CAPTURE_DR: begin hi = TAP_EXIT1_DR;  lo = TAP_SHIFT_DR;   end
         TAP_SHIFT_DR:   begin hi = TAP_EXIT1_DR;  lo = TAP_SHIFT_DR;   end
         TAP_EXIT1_DR:   begin hi = TAP_UPDATE_DR; lo = TAP_PAUSE_DR;   end
         TAP_PAUSE_DR:   begin hi = TAP_EXIT2_DR;  lo = TAP_PAUSE_DR;   end
         TAP_EXIT2_DR:   begin hi = TAP_UPDATE_DR; lo = TAP_SHIFT_DR;   end
         TAP_UPDATE_DR:  begin hi = TAP_SELECT_DR; lo = TAP_IDLE;       end
         TAP_SELECT_IR:  begin hi = TAP_RESET;     lo = TAP_CAPTURE_IR; end
         TAP_CAPTURE_IR: begin hi = TAP_EXIT1_IR;  lo = TAP_SHIFT_IR;   end
         TAP_SHIFT_IR:   begin hi = TAP_EXIT1_IR;  lo = TAP_SHIFT_IR;   end
         TAP_EXIT1_IR:   begin hi = TAP_UPDATE_IR; lo = TAP_PAUSE_IR;   end
         TAP_PAUSE_IR:   begin hi = TAP_EXIT2_IR;  lo = TAP_PAUSE_IR;   end
         TAP_EXIT2_IR:   begin hi = TAP_UPDATE_IR; lo = TAP_SHIFT_IR;   end
         default:        begin hi = TAP_SELECT_DR; lo = TAP_IDLE;       end
      endcase
      return tms ? hi : lo;
   endfunction

   task automatic predict_pins(input logic tck, input logic tms, input logic tdi,
                               input logic [DM_DATA_W-1:0] rd, input logic ok,
                               output result_type r);
      int unsigned          a;
      int unsigned          len;
      logic [1:0]           op;
      logic [1:0]           status;
      r = '0;
      a = (cfg_abits < ABITS_MIN) ? ABITS_MIN : ((cfg_abits > ABITS_MAX) ? ABITS_MAX : cfg_abits);
      status = ok ? DMI_STATUS_OK : DMI_STATUS_FAILED;
      if (!prev_tck && tck) begin
         if (tap == TAP_SHIFT_DR) begin
            len  = (scan_len == 0) ? 1 : ((scan_len > LEN_MAX) ? LEN_MAX : scan_len);
            scan = (scan >> 1) | (DATA_W'(prev_tdi) << (len - 1));
         end else if (tap == TAP_SHIFT_IR) begin
            ir = {prev_tdi, ir[IR_W-1:1]};
         end
         tap = tap_after(tap, prev_tms);
      end else if (prev_tck && !tck) begin
         case (tap)
            TAP_CAPTURE_DR: begin
               case (ir)
                  IR_IDCODE: begin
                     scan     = DATA_W'(cfg_id);
                     scan_len = LEN_WORD;
                  end
                  IR_DTMCS: begin
                     scan = (DATA_W'(busy) << DTMCS_BUSY_BIT) | (DATA_W'(a) << DTMCS_ABITS_LSB)
                          | DATA_W'(1);
                     scan_len = LEN_WORD;
                  end
                  IR_DMI: begin
                     scan     = DATA_W'(dmi_res);
                     scan_len = LEN_W'(a) + LEN_DMI_FIXED;
                  end
                  default: begin
                     scan     = '0;
                     scan_len = LEN_BYPASS;
                  end
               endcase
            end
            TAP_UPDATE_DR: begin
               if (ir == IR_DMI) begin
                  op = scan[1:0];
                  if (op == DMI_OP_READ || op == DMI_OP_WRITE) begin
                     r.dmi_req_valid = 1'b1;
                     r.dmi_req_addr  = DM_ADDR_W'((scan >> 34) & ((DATA_W'(1) << a) - 1));
                     busy            = !ok;
                     if (op == DMI_OP_WRITE) begin
                        r.dmi_req_write = 1'b1;
                        r.dmi_req_data  = scan[33:2];
                        dmi_res         = {32'd0, status};
                     end else begin
                        dmi_res = {rd, status};
                     end
                  end else begin
                     dmi_res = '0;
                     busy    = 1'b0;
                  end
               end
            end
            TAP_SHIFT_DR: tdo_q = scan[0];
            TAP_SHIFT_IR: tdo_q = ir[0];
            default: ;
         endcase
      end
      prev_tck    = tck;
      prev_tms    = tms;
      prev_tdi    = tdi;
      r.tdo       = tdo_q;
      r.tap_state = tap;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type next_want;
      if (reset) begin
         expected_q.delete();
         cfg_abits = ABITS_RESET;
         cfg_id    = ID_CODE_RESET;
         prev_tck  = 1'b0;
         prev_tms  = 1'b0;
         prev_tdi  = 1'b0;
         tdo_q     = 1'b0;
         tap       = TAP_RESET;
         ir        = IR_IDCODE;
         scan      = '0;
         scan_len  = LEN_BYPASS;
         dmi_res   = '0;
         busy      = 1'b0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if ((paddr >> 2) == CSR_ADDR_W'(CSR_ADDRESS_BITS)) begin
               cfg_abits = pwdata[ABITS_W-1:0];
            end else if ((paddr >> 2) == CSR_ADDR_W'(CSR_ID_CODE)) begin
               cfg_id = pwdata[DM_DATA_W-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result item with no item waiting for it");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("tdo", 32'(want.tdo), 32'(rsp_tdo));
               check_field("tap_state", 32'(want.tap_state), 32'(rsp_tap_state));
               check_field("dmi_req_valid", 32'(want.dmi_req_valid), 32'(rsp_dmi_req_valid));
               check_field("dmi_req_write", 32'(want.dmi_req_write), 32'(rsp_dmi_req_write));
               check_field("dmi_req_addr", 32'(want.dmi_req_addr), 32'(rsp_dmi_req_addr));
               check_field("dmi_req_data", want.dmi_req_data, rsp_dmi_req_data);
            end
         end
         if (req_valid && req_ready) begin
            predict_pins(req_tck, req_tms, req_tdi, req_dm_read_data, req_dm_ok, next_want);
            expected_q.push_back(next_want);
         end
      end
      pending = expected_q.size();
   end

endmodule

@@ sim/tb_jtag_debug_transport_core.sv @@
// testbench top for the jtag debug transport: pin-sample stimulus, config phases and verdict
`timescale 1ns / 1ps

module tb_jtag_debug_transport_core
   import jdt_pkg::*;
;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int PHASES = 6;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_tck;
   logic                  req_tms;
   logic                  req_tdi;
   logic [DM_DATA_W-1:0]  req_dm_read_data;
   logic                  req_dm_ok;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_tdo;
   logic [3:0]            rsp_tap_state;
   logic                  rsp_dmi_req_valid;
   logic                  rsp_dmi_req_write;
   logic [DM_ADDR_W-1:0]  rsp_dmi_req_addr;
   logic [DM_DATA_W-1:0]  rsp_dmi_req_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    sent_count = 0;
   int                    rsp_hold = 0;
   logic                  rsp_fire = 1'b0;
   logic                  idle_on = 1'b1;
   logic                  oversample = 1'b0;
   int unsigned           cur_abits = ABITS_RESET;
   logic [IR_W-1:0]       ir_now = IR_IDCODE;

   jtag_debug_transport_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_tck           (req_tck),
      .req_tms           (req_tms),
      .req_tdi           (req_tdi),
      .req_dm_read_data  (req_dm_read_data),
      .req_dm_ok         (req_dm_ok),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tdo           (rsp_tdo),
      .rsp_tap_state     (rsp_tap_state),
      .rsp_dmi_req_valid (rsp_dmi_req_valid),
      .rsp_dmi_req_write (rsp_dmi_req_write),
      .rsp_dmi_req_addr  (rsp_dmi_req_addr),
      .rsp_dmi_req_data  (rsp_dmi_req_data),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   jtag_debug_transport_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_tck           (req_tck),
      .req_tms           (req_tms),
      .req_tdi           (req_tdi),
      .req_dm_read_data  (req_dm_read_data),
      .req_dm_ok         (req_dm_ok),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tdo           (rsp_tdo),
      .rsp_tap_state     (rsp_tap_state),
      .rsp_dmi_req_valid (rsp_dmi_req_valid),
      .rsp_dmi_req_write (rsp_dmi_req_write),
      .rsp_dmi_req_addr  (rsp_dmi_req_addr),
      .rsp_dmi_req_data  (rsp_dmi_req_data),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side back-pressure, one draw per accepted result item
   always @(posedge clock) begin
      rsp_fire <= rsp_valid && rsp_ready;
   end

   always @(negedge clock) begin
      if (rsp_fire) begin
         rsp_hold = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic reply_ok();
      return $urandom_range(0, 4) != 0;
   endfunction

   // called and returns at a falling edge
   task automatic send_sample(input logic tck, input logic tms, input logic tdi,
                              input logic [DM_DATA_W-1:0] rd, input logic ok);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_tck          <= tck;
      req_tms          <= tms;
      req_tdi          <= tdi;
      req_dm_read_data <= rd;
      req_dm_ok        <= ok;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
   endtask

   // one tck period; the first low sample carries the reply, the last one tms and tdi
   task automatic tick(input logic tms, input logic tdi, input logic [DM_DATA_W-1:0] rd,
                       input logic ok);
      int n_lo;
      int n_hi;
      n_lo = oversample ? $urandom_range(1, 3) : 1;
      n_hi = oversample ? $urandom_range(1, 3) : 1;
      for (int i = 0; i < n_lo; i++) begin
         send_sample(1'b0,
                     (i == n_lo - 1) ? tms : 1'($urandom),
                     (i == n_lo - 1) ? tdi : 1'($urandom),
                     (i == 0) ? rd : $urandom,
                     (i == 0) ? ok : 1'($urandom));
      end
      for (int i = 0; i < n_hi; i++) begin
         send_sample(1'b1, 1'($urandom), 1'($urandom), $urandom, 1'($urandom));
      end
   endtask

   task automatic tap_reset_idle();
      repeat (5) tick(1'b1, 1'($urandom), $urandom, reply_ok());
      tick(1'b0, 1'($urandom), $urandom, reply_ok());
   endtask

   // from run-test/idle back to run-test/idle
   task automatic load_ir(input logic [IR_W-1:0] code);
      tick(1'b1, 1'($urandom), $urandom, reply_ok());
      tick(1'b1, 1'($urandom), $urandom, reply_ok());
      tick(1'b0, 1'($urandom), $urandom, reply_ok());
      tick(1'b0, 1'($urandom), $urandom, reply_ok());
      for (int i = 0; i < IR_W; i++) begin
         tick(i == IR_W - 1, code[i], $urandom, reply_ok());
      end
      tick(1'b1, 1'($urandom), $urandom, reply_ok());
      tick(1'b0, 1'($urandom), $urandom, reply_ok());
      ir_now = code;
   endtask

   // capture, shift nbits, optional pause, update; rd and ok answer the update
   task automatic scan_dr(input logic [DATA_W-1:0] bits, input int nbits, input int pauses,
                          input logic [DM_DATA_W-1:0] rd, input logic ok);
      tick(1'b1, 1'($urandom), $urandom, reply_ok());
      tick(1'b0, 1'($urandom), $urandom, reply_ok());
      tick(1'b0, 1'($urandom), $urandom, reply_ok());
      for (int i = 0; i < nbits; i++) begin
         tick(i == nbits - 1, bits[i], $urandom, reply_ok());
      end
      if (pauses > 0) begin
         repeat (pauses) tick(1'b0, 1'($urandom), $urandom, reply_ok());
         tick(1'b1, 1'($urandom), $urandom, reply_ok());
      end
      tick(1'b1, 1'($urandom), $urandom, reply_ok());
      tick(1'b0, 1'($urandom), rd, ok);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [ABITS_W-1:0] abits, input logic [DM_DATA_W-1:0] id);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_write({CSR_ADDRESS_BITS, 2'b00}, CSR_DATA_W'(abits));
      csr_write({CSR_ID_CODE, 2'b00}, id);
      cur_abits = (abits < ABITS_MIN) ? ABITS_MIN : ((abits > ABITS_MAX) ? ABITS_MAX : abits);
   endtask

   task automatic random_step();
      int             roll;
      int             nbits;
      logic [1:0]     op;
      logic [IR_W-1:0] code;
      roll       = $urandom_range(0, 99);
      oversample = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 19) == 0) begin
         idle_on = !idle_on;
      end
      if (roll < 55) begin
         if (ir_now != IR_DMI) begin
            load_ir(IR_DMI);
         end
         op    = $urandom_range(0, 5) < 2 ? 2'($urandom) : ($urandom_range(0, 1) ? DMI_OP_READ
                                                                          : DMI_OP_WRITE);
         nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : cur_abits + 34;
         scan_dr({30'($urandom), 32'($urandom), op}, nbits,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, $urandom, reply_ok());
      end else if (roll < 67) begin
         case ($urandom_range(0, 4))
            0: code = IR_IDCODE;
            1: code = IR_DTMCS;
            2: code = IR_DMI;
            3: code = IR_BYPASS;
            default: code = 5'($urandom);
         endcase
         load_ir(code);
      end else if (roll < 80) begin
         nbits = $urandom_range(0, 1) ? 32 : $urandom_range(1, 64);
         scan_dr({$urandom, $urandom}, nbits, ($urandom_range(0, 3) == 0) ? 1 : 0,
                 $urandom, reply_ok());
      end else if (roll < 88) begin
         repeat ($urandom_range(1, 6)) begin
            send_sample(1'($urandom), 1'($urandom), 1'($urandom), $urandom, 1'($urandom));
         end
         tap_reset_idle();
      end else if (roll < 93) begin
         tap_reset_idle();
      end else begin
         repeat ($urandom_range(1, 4)) tick(1'b0, 1'($urandom), $urandom, reply_ok());
      end
   endtask

   initial begin
      logic [ABITS_W-1:0]   phase_abits[PHASES];
      logic [DM_DATA_W-1:0] phase_id[PHASES];
      int                   phase_end;
      phase_abits = '{ABITS_RESET, 5'd0, 5'd31, ABITS_MIN, ABITS_MAX, 5'($urandom_range(2, 29))};
      phase_id    = '{ID_CODE_RESET, 32'h0, 32'hffffffff, $urandom, $urandom, $urandom};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_tck          = 1'b0;
      req_tms          = 1'b0;
      req_tdi          = 1'b0;
      req_dm_read_data = '0;
      req_dm_ok        = 1'b0;
      rsp_ready        = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset values, every instruction, every op, failed replies, pause path
      idle_on = 1'b0;
      tap_reset_idle();
      scan_dr({$urandom, $urandom}, 32, 0, $urandom, 1'b1);
      load_ir(IR_DMI);
      scan_dr({30'h3fffffff, 32'hffffffff, DMI_OP_WRITE}, cur_abits + 34, 0, '0, 1'b1);
      scan_dr({30'h0, 32'h0, DMI_OP_READ}, cur_abits + 34, 2, 32'hffffffff, 1'b0);
      load_ir(IR_DTMCS);
      scan_dr('0, 32, 0, $urandom, 1'b1);
      load_ir(IR_DMI);
      scan_dr({30'h0, 32'h0, DMI_OP_NOP}, cur_abits + 34, 0, $urandom, 1'b1);
      scan_dr({30'h15, 32'h0, DMI_OP_WRITE}, cur_abits + 34, 0, $urandom, 1'b0);
      scan_dr({30'h2a, 32'h12345678, 2'b11}, cur_abits + 34, 0, $urandom, 1'b1);
      scan_dr({30'h7f, 32'h0, DMI_OP_READ}, cur_abits + 34, 0, 32'h0, 1'b1);
      load_ir(IR_BYPASS);
      scan_dr({$urandom, $urandom}, 8, 0, $urandom, 1'b1);
      load_ir(5'h00);
      scan_dr({$urandom, $urandom}, 4, 1, $urandom, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         set_config(phase_abits[p], phase_id[p]);
         idle_on = (p % 3) != 2;
         tap_reset_idle();
         ir_now = IR_IDCODE;
         phase_end = sent_count + RANDOM_ITEMS / PHASES;
         while (sent_count < phase_end) begin
            random_step();
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
